// ----- hw/rtl/wsp_pkg.sv -----
// shared types and constants for the wav stream to stereo pcm16 parser
package wsp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
	localparam logic [7:0]  PCM_OFFSET     = 8'd128;

	localparam int OUT_TDATA_W = 72;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHDR,
		PH_FMT,
		PH_DATA,
		PH_SKIP,
		PH_IGNORE
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_BAD_TAG,
		ST_OVERRUN,
		ST_MISSING,
		ST_NOT_PCM,
		ST_BAD_BITS,
		ST_BAD_CHAN
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] left_sample;
		logic [15:0] right_sample;
		status_t     status_code;
		logic [31:0] rate_hz;
		logic        is_last;
	} result_t;

	// up to two results per byte, a first then b
	typedef struct packed {
		logic    va;
		result_t a;
		logic    vb;
		result_t b;
	} push_t;

	function automatic logic [15:0] conv8(input logic [7:0] b);
		logic [7:0] d;
		d = b - PCM_OFFSET;
		return {d, 8'h00};
	endfunction

endpackage

// ----- hw/rtl/wsp_parser.sv -----
// byte-level riff/wave chunk walker and pcm frame converter
module wsp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [7:0]    file_byte,
	input  logic          end_of_file,
	output wsp_pkg::push_t push
);
	import wsp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] total_q, total_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] len_q, len_n;
	logic [31:0] off_q, off_n;
	logic [15:0] fmt_q, fmt_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic        seen_fmt_q, seen_fmt_n;
	logic        seen_data_q, seen_data_n;
	logic [16:0] fbi_q, fbi_n;
	logic [15:0] hl_q, hl_n;
	logic [7:0]  hlb_q, hlb_n;
	status_t     err_q, err_n;

	logic        emit;
	logic [15:0] frame_l;
	logic [15:0] frame_r;
	status_t     stat;
	logic [31:0] stat_rate;

	function automatic status_t check_data(input logic sf, input logic [31:0] ln,
		input logic [15:0] ch, input logic [31:0] rt, input logic [15:0] fc,
		input logic [15:0] sb);
		status_t c;
		if (!sf || ln == 32'd0 || ch == 16'd0 || rt == 32'd0) c = ST_MISSING;
		else if (fc != 16'd1) c = ST_NOT_PCM;
		else if (sb == 16'd16) c = (ch > 16'd2) ? ST_BAD_CHAN : ST_OK;
		else if (sb == 16'd8) c = ST_OK;
		else c = ST_BAD_BITS;
		return c;
	endfunction

	always_comb begin
		logic [31:0] pos;
		logic [32:0] body;
		logic [16:0] fb;
		logic [17:0] inext;
		status_t     c;
		logic        mono;

		pos = off_q;
		phase_n = phase_q;
		total_n = (total_q != 32'hFFFF_FFFF) ? total_q + 32'd1 : total_q;
		tag_n = tag_q;
		len_n = len_q;
		off_n = off_q;
		fmt_n = fmt_q;
		chan_n = chan_q;
		rate_n = rate_q;
		bits_n = bits_q;
		seen_fmt_n = seen_fmt_q;
		seen_data_n = seen_data_q;
		fbi_n = fbi_q;
		hl_n = hl_q;
		hlb_n = hlb_q;
		err_n = err_q;
		emit = 1'b0;
		frame_l = 16'd0;
		frame_r = 16'd0;
		body = {1'b0, len_q} + {32'd0, len_q[0]};
		mono = (chan_q == 16'd1);
		fb = (bits_q == 16'd16) ? {chan_q, 1'b0} : {1'b0, chan_q};
		inext = {1'b0, fbi_q} + 18'd1;
		c = ST_OK;

		case (phase_q)
			PH_HEADER: begin
				tag_n = {file_byte, tag_q[31:8]};
				off_n = pos + 32'd1;
				if (pos == 32'd3 && tag_n != TAG_RIFF) begin
					err_n = ST_BAD_TAG;
					phase_n = PH_IGNORE;
				end else if (pos == 32'd11) begin
					if (tag_n != TAG_WAVE) begin
						err_n = ST_BAD_TAG;
						phase_n = PH_IGNORE;
					end else begin
						phase_n = PH_CHDR;
						off_n = 32'd0;
					end
				end
			end
			PH_CHDR: begin
				if (pos < 32'd4) begin
					tag_n = {file_byte, tag_q[31:8]};
					if (pos == 32'd0) len_n = 32'd0;
				end else begin
					len_n[{pos[1:0], 3'b000} +: 8] = len_q[{pos[1:0], 3'b000} +: 8] | file_byte;
				end
				off_n = pos + 32'd1;
				if (pos >= 32'd7) begin
					off_n = 32'd0;
					if (tag_n == TAG_FMT && len_n >= 32'd16 && !seen_data_q) begin
						seen_fmt_n = 1'b1;
						phase_n = PH_FMT;
					end else if (tag_n == TAG_DATA && !seen_data_q) begin
						seen_data_n = 1'b1;
						c = check_data(seen_fmt_q, len_n, chan_q, rate_q, fmt_q, bits_q);
						fbi_n = 17'd0;
						if (c != ST_OK) begin
							err_n = c;
							phase_n = PH_SKIP;
						end else begin
							phase_n = PH_DATA;
						end
					end else begin
						phase_n = PH_SKIP;
					end
					if (len_n == 32'd0) phase_n = PH_CHDR;
				end
			end
			PH_FMT, PH_DATA, PH_SKIP: begin
				if (phase_q == PH_FMT) begin
					if (pos < 32'd2) fmt_n[{pos[0], 3'b000} +: 8] = file_byte;
					else if (pos < 32'd4) chan_n[{pos[0], 3'b000} +: 8] = file_byte;
					else if (pos < 32'd8) rate_n[{pos[1:0], 3'b000} +: 8] = file_byte;
					else if (pos == 32'd14 || pos == 32'd15)
						bits_n[{pos[0], 3'b000} +: 8] = file_byte;
				end else if (phase_q == PH_DATA && pos < len_q) begin
					if (bits_q == 16'd16) begin
						if (fbi_q == 17'd0 || fbi_q == 17'd2) begin
							hlb_n = file_byte;
						end else if (fbi_q == 17'd1) begin
							hl_n = {file_byte, hlb_q};
							emit = mono;
						end else begin
							emit = 1'b1;
						end
						frame_l = hl_n;
						frame_r = mono ? hl_n : {file_byte, hlb_n};
					end else begin
						if (fbi_q == 17'd0) hl_n = conv8(file_byte);
						else if (fbi_q == 17'd1) hlb_n = file_byte;
						emit = (inext == {1'b0, fb});
						frame_l = hl_n;
						frame_r = mono ? hl_n : conv8(hlb_n);
					end
					fbi_n = (inext >= {1'b0, fb}) ? 17'd0 : inext[16:0];
				end
				if ({1'b0, pos} + 33'd1 >= body) begin
					phase_n = PH_CHDR;
					off_n = 32'd0;
				end else begin
					off_n = pos + 32'd1;
				end
			end
			default: begin
			end
		endcase

		if (total_n < MIN_FILE_BYTES) stat = ST_SHORT;
		else if (err_n == ST_BAD_TAG) stat = ST_BAD_TAG;
		else if (phase_n == PH_FMT || phase_n == PH_DATA || phase_n == PH_SKIP) stat = ST_OVERRUN;
		else if (err_n != ST_OK) stat = err_n;
		else if (!seen_data_n) stat = ST_MISSING;
		else stat = ST_OK;
		stat_rate = rate_n;

		// end of file returns the parser to reset
		if (end_of_file) begin
			phase_n = PH_HEADER;
			total_n = 32'd0;
			tag_n = 32'd0;
			len_n = 32'd0;
			off_n = 32'd0;
			fmt_n = 16'd0;
			chan_n = 16'd0;
			rate_n = 32'd0;
			bits_n = 16'd0;
			seen_fmt_n = 1'b0;
			seen_data_n = 1'b0;
			fbi_n = 17'd0;
			hl_n = 16'd0;
			hlb_n = 8'd0;
			err_n = ST_OK;
		end
	end

	always_comb begin
		result_t fr;
		result_t st;
		fr = '{kind: 1'b0, left_sample: frame_l, right_sample: frame_r,
			status_code: ST_OK, rate_hz: 32'd0, is_last: 1'b0};
		st = '{kind: 1'b1, left_sample: 16'd0, right_sample: 16'd0,
			status_code: stat, rate_hz: stat_rate, is_last: 1'b1};
		push.va = en && (emit || end_of_file);
		push.a  = emit ? fr : st;
		push.vb = en && emit && end_of_file;
		push.b  = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			total_q <= 32'd0;
			tag_q <= 32'd0;
			len_q <= 32'd0;
			off_q <= 32'd0;
			fmt_q <= 16'd0;
			chan_q <= 16'd0;
			rate_q <= 32'd0;
			bits_q <= 16'd0;
			seen_fmt_q <= 1'b0;
			seen_data_q <= 1'b0;
			fbi_q <= 17'd0;
			hl_q <= 16'd0;
			hlb_q <= 8'd0;
			err_q <= ST_OK;
		end else if (en) begin
			phase_q <= phase_n;
			total_q <= total_n;
			tag_q <= tag_n;
			len_q <= len_n;
			off_q <= off_n;
			fmt_q <= fmt_n;
			chan_q <= chan_n;
			rate_q <= rate_n;
			bits_q <= bits_n;
			seen_fmt_q <= seen_fmt_n;
			seen_data_q <= seen_data_n;
			fbi_q <= fbi_n;
			hl_q <= hl_n;
			hlb_q <= hlb_n;
			err_q <= err_n;
		end
	end

endmodule

// ----- hw/rtl/wsp_out_fifo.sv -----
// result queue taking up to two results per cycle and giving one per transfer
module wsp_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  wsp_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output wsp_pkg::result_t out_data
);
	import wsp_pkg::*;

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;
	logic [1:0]           npush;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign npush     = {1'b0, push.va} + {1'b0, push.vb};
	// two free entries needed before the parser may take a byte
	assign room      = (count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.va) mem_q[wr_q] <= push.a;
		if (push.vb) mem_q[wr_q + FIFO_AW'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_AW'(npush);
			if (pop) rd_q <= rd_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW + 1)'(npush) - (FIFO_AW + 1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.va || push.vb) |-> count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 2))
		else $error("result pushed without two free entries");

	a_b_after_a: assert property (@(posedge clk) disable iff (!arst_n)
		push.vb |-> (push.va && !push.a.kind && push.b.kind))
		else $error("second result without a frame ahead of it");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.kind == out_data.is_last))
		else $error("status result and last flag disagree");

endmodule

// ----- hw/rtl/wav_stream_to_stereo_pcm16.sv -----
// top level of the wav byte stream to stereo pcm16 frame parser
// One file byte is taken per cycle while the queue has room, parsed in a
// single pass from an input register into a four-entry result queue; a
// frame reaches the master side once its last byte has passed the input
// register into the queue. The byte marked by tlast gives a status transfer
// (tuser high, tlast high, rate in tdata) after any frame it completes, so
// that byte costs up to two output transfers. The slave side accepts a byte
// in every cycle while the result queue holds two or fewer entries, which a
// master side taking one transfer per cycle always allows. After the status
// transfer the parser is back in reset and the next byte starts a new file.
module wav_stream_to_stereo_pcm16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // file_byte
	input  logic        s_axis_tlast,  // end_of_file
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [wsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// left_sample[15:0], right_sample[31:16], status_code[34:32], rate_hz[66:35]
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast   // is_last
);
	import wsp_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       room;
	logic       consume;
	push_t      push;
	result_t    res;

	assign consume       = v_s1 && room;
	assign s_axis_tready = !v_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eof_s1 <= s_axis_tlast;
		end
	end

	wsp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (consume),
		.file_byte   (byte_s1),
		.end_of_file (eof_s1),
		.push        (push)
	);

	wsp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {5'd0, res.rate_hz, res.status_code, res.right_sample,
		res.left_sample};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.is_last;

endmodule
